/* src/psrw_pkg.sv */
`timescale 1ns / 1ps
package psrw_pkg;

  localparam int SENDERS = 32;
  localparam int WINDOW  = 64;

  localparam int SENDER_W = 5;
  localparam int SEQ_W    = 16;
  localparam int SIDX_W   = (SENDERS > 1) ? $clog2(SENDERS) : 1;

  localparam logic [63:0] WIN_MASK = {64{1'b1}} >> (64 - WINDOW);
  localparam logic [SEQ_W-1:0] WIN_DIST = SEQ_W'(WINDOW);

  typedef enum logic [2:0] {
    ST_FIRST   = 3'd0,
    ST_NEWER   = 3'd1,
    ST_LATE    = 3'd2,
    ST_DUP     = 3'd3,
    ST_OLD     = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

  typedef struct packed {
    logic              clear;
    logic              in_range;
    logic [SIDX_W-1:0] idx;
    logic [SEQ_W-1:0]  seq;
  } item_t;

  typedef struct packed {
    logic [SEQ_W-1:0] highest;
    logic [63:0]      bitmap;
  } entry_t;

endpackage

/* src/psrw_front.sv */
`timescale 1ns / 1ps
module psrw_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           kind,
  input  logic [psrw_pkg::SENDER_W-1:0]  sender,
  input  logic [psrw_pkg::SEQ_W-1:0]     seq_number,
  output logic                           q_valid,
  output psrw_pkg::item_t                q_item,
  input  logic                           q_pop
);
  import psrw_pkg::*;

  item_t       slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  item_t       incoming;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];

  always_comb begin
    incoming.clear    = kind;
    incoming.in_range = (32'(sender) < SENDERS);
    incoming.idx      = SIDX_W'(sender);
    incoming.seq      = seq_number;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/psrw_back.sv */
`timescale 1ns / 1ps
module psrw_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  psrw_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            accepted,
  output logic [2:0]      status
);
  import psrw_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_EXEC = 2'b10
  } bstate_t;

  bstate_t           state;
  bstate_t           state_next;
  item_t             cur;
  entry_t            mem [SENDERS];
  entry_t            rd;
  logic [SENDERS-1:0] started;

  logic              done;
  logic              we;
  entry_t            wdata;
  logic              set_start;
  logic              clr_start;
  logic              acc_next;
  status_t           status_next;
  logic [SEQ_W-1:0]  fwd;
  logic [SEQ_W-1:0]  bwd;
  logic              cur_started;

  assign q_pop = (state == B_IDLE) && q_valid;
  assign done  = (state == B_EXEC) && (!out_valid || !out_stall);
  assign fwd   = cur.seq - rd.highest;
  assign bwd   = rd.highest - cur.seq;
  assign cur_started = started[cur.idx];

  always_comb begin
    we          = 1'b0;
    wdata       = rd;
    set_start   = 1'b0;
    clr_start   = 1'b0;
    acc_next    = 1'b0;
    status_next = ST_OLD;
    if (!cur.in_range) begin
      status_next = cur.clear ? ST_CLEARED : ST_OLD;
    end else if (cur.clear) begin
      clr_start   = 1'b1;
      status_next = ST_CLEARED;
    end else if (!cur_started) begin
      set_start     = 1'b1;
      we            = 1'b1;
      wdata.highest = cur.seq;
      wdata.bitmap  = 64'd1;
      acc_next      = 1'b1;
      status_next   = ST_FIRST;
    end else if (fwd != '0 && !fwd[SEQ_W-1]) begin
      we            = 1'b1;
      wdata.highest = cur.seq;
      if (fwd >= WIN_DIST) begin
        wdata.bitmap = 64'd1;
      end else begin
        wdata.bitmap = ((rd.bitmap << fwd[5:0]) | 64'd1) & WIN_MASK;
      end
      acc_next    = 1'b1;
      status_next = ST_NEWER;
    end else if (!bwd[SEQ_W-1]) begin
      if (bwd == '0) begin
        status_next = ST_DUP;
      end else if (bwd >= WIN_DIST) begin
        status_next = ST_OLD;
      end else if (rd.bitmap[bwd[5:0]]) begin
        status_next = ST_DUP;
      end else begin
        we           = 1'b1;
        wdata.bitmap = rd.bitmap | (64'd1 << bwd[5:0]);
        acc_next     = 1'b1;
        status_next  = ST_LATE;
      end
    end
  end

  always_comb begin
    case (state)
      B_IDLE:  state_next = q_pop ? B_EXEC : B_IDLE;
      B_EXEC:  state_next = done ? B_IDLE : B_EXEC;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (done && we) begin
      mem[cur.idx] <= wdata;
    end
    if (q_pop) begin
      rd  <= mem[q_item.idx];
      cur <= q_item;
    end
    if (done) begin
      accepted <= acc_next;
      status   <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      started   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (done && set_start) begin
        started[cur.idx] <= 1'b1;
      end else if (done && clr_start) begin
        started[cur.idx] <= 1'b0;
      end
      if (done) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* src/per_sender_replay_window_core.sv */
`timescale 1ns / 1ps
// Anti-replay checker with a separate 64-entry sliding window for each of 32 senders. Each input
// beat either checks a 16-bit sequence number for one sender or clears that sender's slot, and
// gives exactly one result beat with an accept flag and a status code. Input beats enter a
// two-entry queue, so the source is stalled only when that queue is full. The checker takes one beat
// at a time, reading the sender's entry from its memory with a registered read and then updating it,
// but it waits to update while the previous result is still held for the sink. A result waits in an
// output register while the sink stalls, and the next beat is already queued meanwhile. Reset
// clears only one start flag per sender, so the block is ready in the cycle after reset.
module per_sender_replay_window_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [psrw_pkg::SENDER_W-1:0] sender,
  input  logic [psrw_pkg::SEQ_W-1:0]    seq_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          accepted,
  output logic [2:0]                    status
);
  import psrw_pkg::*;

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  psrw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .sender     (sender),
    .seq_number (seq_number),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  psrw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .accepted  (accepted),
    .status    (status)
  );

endmodule

/* bench/tb_per_sender_replay_window_core.sv */
`timescale 1ns / 1ps
module tb_per_sender_replay_window_core;
  import psrw_pkg::*;

  localparam logic KIND_CHECK = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;
  localparam logic [SEQ_W-1:0] HALF_DIST = 16'h8000;
  localparam int IDLE_LIMIT = 2000;
  localparam int SHOWN_MISMATCHES = 10;

  typedef struct {
    logic                kind;
    logic [SENDER_W-1:0] who;
    logic [SEQ_W-1:0]    seq;
    logic                acc;
    status_t             st;
  } verdict_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                kind = KIND_CHECK;
  logic [SENDER_W-1:0] sender = '0;
  logic [SEQ_W-1:0]    seq_number = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                accepted;
  logic [2:0]          status;

  logic             win_open [SENDERS];
  logic [SEQ_W-1:0] top_seq  [SENDERS];
  logic [63:0]      seen_map [SENDERS];

  verdict_t verdict_q[$];
  int src_busy = 20;
  int sink_busy = 20;
  int beats_in = 0;
  int results_checked = 0;
  int mismatches = 0;
  int status_seen [6];

  per_sender_replay_window_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .sender     (sender),
    .seq_number (seq_number),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .accepted   (accepted),
    .status     (status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic verdict_t replay_verdict(input logic k, input logic [SENDER_W-1:0] who,
                                              input logic [SEQ_W-1:0] sq);
    verdict_t v;
    logic [SEQ_W-1:0] fwd, bwd;
    logic [SIDX_W-1:0] s;
    v.kind = k;
    v.who = who;
    v.seq = sq;
    v.acc = 1'b0;
    if (int'(who) >= SENDERS) begin
      v.st = (k == KIND_CLEAR) ? ST_CLEARED : ST_OLD;
      return v;
    end
    s = SIDX_W'(who);
    if (k == KIND_CLEAR) begin
      win_open[s] = 1'b0;
      top_seq[s] = '0;
      seen_map[s] = '0;
      v.st = ST_CLEARED;
      return v;
    end
    if (!win_open[s]) begin
      win_open[s] = 1'b1;
      top_seq[s] = sq;
      seen_map[s] = 64'd1;
      v.acc = 1'b1;
      v.st = ST_FIRST;
      return v;
    end
    fwd = sq - top_seq[s];
    bwd = top_seq[s] - sq;
    if (fwd != 0 && fwd < HALF_DIST) begin
      if (fwd >= WINDOW) seen_map[s] = 64'd1;
      else seen_map[s] = ((seen_map[s] << fwd) | 64'd1) & WIN_MASK;
      top_seq[s] = sq;
      v.acc = 1'b1;
      v.st = ST_NEWER;
    end else if (bwd < HALF_DIST) begin
      if (bwd == 0) begin
        v.st = ST_DUP;
      end else if (bwd >= WINDOW) begin
        v.st = ST_OLD;
      end else if (seen_map[s][bwd[5:0]]) begin
        v.st = ST_DUP;
      end else begin
        seen_map[s][bwd[5:0]] = 1'b1;
        v.acc = 1'b1;
        v.st = ST_LATE;
      end
    end else begin
      v.st = ST_OLD;
    end
    return v;
  endfunction

  function automatic int pick_gap(input int busy_pct);
    if ($urandom_range(99) >= busy_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 8);
    return $urandom_range(3, 1);
  endfunction

  task automatic send_beat(input logic k, input logic [SENDER_W-1:0] who,
                           input logic [SEQ_W-1:0] sq);
    int gap;
    gap = pick_gap(src_busy);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    sender <= who;
    seq_number <= sq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    verdict_q.push_back(replay_verdict(k, who, sq));
    beats_in++;
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (verdict_q.size() != 0);
  endtask

  task automatic test_start_and_wrap();
    send_beat(KIND_CHECK, 5'd0, 16'hFFFF);
    send_beat(KIND_CHECK, 5'd0, 16'h0000);
    send_beat(KIND_CHECK, 5'd0, 16'h0000);
  endtask

  task automatic test_window_edges();
    send_beat(KIND_CHECK, 5'd0, 16'hFFC1);
    send_beat(KIND_CHECK, 5'd0, 16'hFFC1);
    send_beat(KIND_CHECK, 5'd0, 16'hFFC0);
    send_beat(KIND_CHECK, 5'd0, 16'h8000);
  endtask

  task automatic test_far_jumps();
    send_beat(KIND_CHECK, 5'd0, 16'h7FFF);
    send_beat(KIND_CHECK, 5'd0, 16'h7FFE);
    send_beat(KIND_CHECK, 5'd0, 16'h803E);
    send_beat(KIND_CHECK, 5'd0, 16'h7FFF);
    send_beat(KIND_CHECK, 5'd0, 16'h807E);
    send_beat(KIND_CHECK, 5'd0, 16'h803F);
  endtask

  task automatic test_clear_slot();
    send_beat(KIND_CHECK, 5'd31, 16'h1234);
    send_beat(KIND_CLEAR, 5'd31, 16'hFFFF);
    send_beat(KIND_CHECK, 5'd31, 16'h0000);
    send_beat(KIND_CLEAR, 5'd31, 16'h0000);
    send_beat(KIND_CLEAR, 5'd5, 16'h5A5A);
    send_beat(KIND_CHECK, 5'd5, 16'hAAAA);
    send_beat(KIND_CHECK, 5'd5, 16'h5555);
  endtask

  task automatic test_random_traffic(input int beats, input int src_pct, input int sink_pct);
    int n, pick;
    logic k;
    logic [SENDER_W-1:0] who;
    logic [SEQ_W-1:0] base, sq;
    src_busy = src_pct;
    sink_busy = sink_pct;
    for (n = 0; n < beats; n++) begin
      who = ($urandom_range(1) == 0) ? SENDER_W'($urandom_range(3)) :
                                       SENDER_W'($urandom_range(31));
      base = top_seq[who];
      k = KIND_CHECK;
      sq = SEQ_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 5) k = KIND_CLEAR;
      else if (pick < 45) sq = base + SEQ_W'($urandom_range(8, 1));
      else if (pick < 70) sq = base - SEQ_W'($urandom_range(63, 1));
      else if (pick < 80) sq = base - SEQ_W'($urandom_range(3, 0));
      else if (pick < 87) sq = base + SEQ_W'($urandom_range(32767, 9));
      else if (pick < 93) sq = base - SEQ_W'($urandom_range(32767, 64));
      else if (pick < 95) sq = base + HALF_DIST;
      send_beat(k, who, sq);
      if ($urandom_range(199) == 0) pause_until_drained();
    end
  endtask

  initial begin
    int gap;
    forever begin
      gap = pick_gap(sink_busy);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        if (mismatches < SHOWN_MISMATCHES)
          $display("Unexpected result beat: accepted=%0b status=%0d", accepted, status);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        results_checked++;
        if (status < 6) status_seen[status]++;
        if (accepted !== want.acc || status !== want.st) begin
          if (mismatches < SHOWN_MISMATCHES)
            $display({"Mismatch for kind=%0b sender=%0d seq=%h: expected accepted=%0b ",
                      "status=%0d, got accepted=%0b status=%0d"},
                     want.kind, want.who, want.seq, want.acc, want.st, accepted, status);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    for (int i = 0; i < SENDERS; i++) begin
      win_open[i] = 1'b0;
      top_seq[i] = '0;
      seen_map[i] = '0;
    end
    for (int i = 0; i < 6; i++) status_seen[i] = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_start_and_wrap();
    test_window_edges();
    test_far_jumps();
    test_clear_slot();
    pause_until_drained();
    test_random_traffic(460, 0, 0);
    pause_until_drained();
    test_random_traffic(460, 30, 30);
    test_random_traffic(460, 70, 10);
    pause_until_drained();
    test_random_traffic(470, 10, 70);
    pause_until_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d beats and checked %0d results with mismatches=%0d.",
             beats_in, results_checked, mismatches);
    $display("Statuses seen: first %0d, newer %0d, late %0d, duplicate %0d, old %0d, cleared %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
             status_seen[5]);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* per_sender_replay_window_core.f */
src/psrw_pkg.sv
src/psrw_front.sv
src/psrw_back.sv
src/per_sender_replay_window_core.sv
bench/tb_per_sender_replay_window_core.sv
